[src/ppp_pkg.sv]
// Shared constants and types for the perspective point projector.
// No dependencies.
package ppp_pkg;

  localparam int FRACTION_BITS  = 16;
  localparam int SCREEN_BITS    = 12;
  localparam int COORD_BITS     = 32;
  localparam int CFG_DATA_BITS  = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int VIEWPORT_BITS  = 13;

  typedef logic [CFG_INDEX_BITS-1:0] reg_index_t;

  localparam reg_index_t REG_ROW_X_FIRST  = 3'd0;
  localparam reg_index_t REG_ROW_X_SECOND = 3'd1;
  localparam reg_index_t REG_ROW_Y_FIRST  = 3'd2;
  localparam reg_index_t REG_ROW_Y_SECOND = 3'd3;
  localparam reg_index_t REG_ROW_W_FIRST  = 3'd4;
  localparam reg_index_t REG_ROW_W_SECOND = 3'd5;
  localparam reg_index_t REG_VP_WIDTH     = 3'd6;
  localparam reg_index_t REG_VP_HEIGHT    = 3'd7;

  localparam logic [VIEWPORT_BITS-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [VIEWPORT_BITS-1:0] HEIGHT_RESET = 13'd480;

endpackage

[src/ppp_point_if.sv]
// Valid/ready channels for world points and screen pixels.
// Depends on ppp_pkg.
interface ppp_point_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [ppp_pkg::COORD_BITS-1:0] world_x;
  logic signed [ppp_pkg::COORD_BITS-1:0] world_y;
  logic signed [ppp_pkg::COORD_BITS-1:0] world_z;
  modport source (output valid, world_x, world_y, world_z, input ready);
  modport sink   (input valid, world_x, world_y, world_z, output ready);
endinterface

interface ppp_pixel_if #(
  parameter int SCREEN_BITS = ppp_pkg::SCREEN_BITS
);
  logic                   valid;
  logic                   ready;
  logic                   visible;
  logic [SCREEN_BITS-1:0] screen_x;
  logic [SCREEN_BITS-1:0] screen_y;
  modport source (output valid, visible, screen_x, screen_y, input ready);
  modport sink   (input valid, visible, screen_x, screen_y, output ready);
endinterface

[src/ppp_div_stage.sv]
// One registered restoring-division step: decides one quotient bit.
// Depends on nothing; used by perspective_point_projector.
module ppp_div_stage #(
  parameter int NW  = 64,
  parameter int CW  = 50,
  parameter int QW  = 13,
  parameter int BIT = 12
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] rem_in,
  input  logic [CW-1:0] d_in,
  input  logic [QW-1:0] q_in,
  output logic [NW-1:0] rem_out,
  output logic [CW-1:0] d_out,
  output logic [QW-1:0] q_out
);

  logic [NW-1:0] shifted;
  logic          take;

  assign shifted = NW'(d_in) << BIT;
  assign take    = rem_in >= shifted;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? rem_in - shifted : rem_in;
      d_out   <= d_in;
      q_out   <= {q_in[QW-2:0], take};
    end
  end

endmodule

[src/perspective_point_projector.sv]
// Top level of the perspective point projector: matrix rows, clip tests,
// pixel mapping. Depends on ppp_pkg, ppp_point_if/ppp_pixel_if, ppp_div_stage.
//
//   channel   dir  transaction
//   points    in   world_x, world_y, world_z (signed fixed point)
//   pixels    out  visible, screen_x, screen_y
//   cfg_*     in   register write, index + 64-bit data
//
// One point per cycle while the output is not stalled; stages: products, clip sums, clip tests,
// numerator multiply, 13 one-bit division stages, final edge check.
// The whole pipeline advances when the output register is empty or taken,
// so a stall freezes every stage in place. Synchronous reset clears the
// valid bits and restores the register defaults.
module perspective_point_projector #(
  parameter int FRACTION_BITS = ppp_pkg::FRACTION_BITS,
  parameter int SCREEN_BITS   = ppp_pkg::SCREEN_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  ppp_point_if.sink                           points,
  ppp_pixel_if.source                         pixels,
  input  logic                                cfg_we,
  input  ppp_pkg::reg_index_t                 cfg_index,
  input  logic [ppp_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  localparam int VB = ppp_pkg::VIEWPORT_BITS;
  localparam int PW = 2 * ppp_pkg::COORD_BITS - FRACTION_BITS;
  localparam int CW = PW + 2;
  localparam int NW = CW + VB + 1;
  localparam int DS = VB;
  localparam logic [VB+2:0] LIMIT = (VB+3)'(1) << SCREEN_BITS;

  // configuration
  logic [ppp_pkg::CFG_DATA_BITS-1:0] coef [6];
  logic [VB-1:0] vp_width;
  logic [VB-1:0] vp_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) coef[i] <= '0;
      vp_width  <= ppp_pkg::WIDTH_RESET;
      vp_height <= ppp_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ppp_pkg::REG_ROW_X_FIRST:  coef[0] <= cfg_data;
        ppp_pkg::REG_ROW_X_SECOND: coef[1] <= cfg_data;
        ppp_pkg::REG_ROW_Y_FIRST:  coef[2] <= cfg_data;
        ppp_pkg::REG_ROW_Y_SECOND: coef[3] <= cfg_data;
        ppp_pkg::REG_ROW_W_FIRST:  coef[4] <= cfg_data;
        ppp_pkg::REG_ROW_W_SECOND: coef[5] <= cfg_data;
        ppp_pkg::REG_VP_WIDTH:     vp_width  <= cfg_data[VB-1:0];
        ppp_pkg::REG_VP_HEIGHT:    vp_height <= cfg_data[VB-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv          = !pixels.valid || pixels.ready;
  assign points.ready = adv;

  // stage 1: nine products, floored to the coordinate scale
  logic                 v1;
  logic signed [PW-1:0] prod [3][3];
  logic signed [63:0]   m    [3][3];
  logic signed [31:0]   cf   [3][3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cf[r][0] = signed'(coef[2*r][63:32]);
      cf[r][1] = signed'(coef[2*r][31:0]);
      cf[r][2] = signed'(coef[2*r+1][63:32]);
      m[r][0]  = cf[r][0] * points.world_x;
      m[r][1]  = cf[r][1] * points.world_y;
      m[r][2]  = cf[r][2] * points.world_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= points.valid;
    if (adv) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          prod[r][c] <= signed'(m[r][c][63:FRACTION_BITS]);
    end
  end

  // stage 2: clip sums
  logic                 v2;
  logic signed [CW-1:0] clip [3];
  logic signed [31:0]   kterm [3];

  always_comb begin
    for (int r = 0; r < 3; r++) kterm[r] = signed'(coef[2*r+1][31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      for (int r = 0; r < 3; r++)
        clip[r] <= CW'(prod[r][0]) + CW'(prod[r][1]) + CW'(prod[r][2]) + CW'(kterm[r]);
    end
  end

  // stage 3: frustum tests, shift into [0, 2w)
  logic                 v3;
  logic                 rej3;
  logic [CW-1:0]        ax3, ay3, w3;
  logic signed [CW-1:0] ncw;
  logic                 reject;

  assign ncw    = -clip[2];
  assign reject = !(clip[2] > 0) || clip[0] >= clip[2] || clip[0] <= ncw
                  || clip[1] >= clip[2] || clip[1] <= ncw;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      rej3 <= reject;
      ax3  <= CW'(clip[0] + clip[2]);
      ay3  <= CW'(clip[1] + clip[2]);
      w3   <= CW'(clip[2]);
    end
  end

  // stage 4: numerators (c + w) * size + w, divisor 2w
  logic          v4;
  logic [NW-1:0] rx [DS+1];
  logic [NW-1:0] ry [DS+1];
  logic [CW-1:0] dx [DS+1];
  logic [CW-1:0] dy [DS+1];
  logic [VB-1:0] qx [DS+1];
  logic [VB-1:0] qy [DS+1];
  logic          vd [DS+1];
  logic          rj [DS+1];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) begin
      rx[0] <= NW'(ax3) * NW'(vp_width) + NW'(w3);
      ry[0] <= NW'(ay3) * NW'(vp_height) + NW'(w3);
      dx[0] <= w3 << 1;
      dy[0] <= w3 << 1;
      qx[0] <= '0;
      qy[0] <= '0;
      rj[0] <= rej3;
    end
  end

  assign vd[0] = v4;

  // division stages, most significant quotient bit first
  for (genvar k = 0; k < DS; k++) begin : g_div
    ppp_div_stage #(.NW(NW), .CW(CW), .QW(VB), .BIT(VB-1-k)) u_x (
      .clk(clk), .en(adv),
      .rem_in(rx[k]), .d_in(dx[k]), .q_in(qx[k]),
      .rem_out(rx[k+1]), .d_out(dx[k+1]), .q_out(qx[k+1])
    );
    ppp_div_stage #(.NW(NW), .CW(CW), .QW(VB), .BIT(VB-1-k)) u_y (
      .clk(clk), .en(adv),
      .rem_in(ry[k]), .d_in(dy[k]), .q_in(qy[k]),
      .rem_out(ry[k+1]), .d_out(dy[k+1]), .q_out(qy[k+1])
    );
    always_ff @(posedge clk) begin
      if (rst) vd[k+1] <= 1'b0;
      else if (adv) vd[k+1] <= vd[k];
      if (adv) rj[k+1] <= rj[k];
    end
  end

  // output stage: viewport and screen-field edge checks
  logic          vis;
  logic [VB+2:0] px_ext, py_ext;

  assign px_ext = (VB+3)'(qx[DS]);
  assign py_ext = (VB+3)'(qy[DS]);
  assign vis    = !rj[DS] && qx[DS] < vp_width && qy[DS] < vp_height
                  && px_ext < LIMIT && py_ext < LIMIT;

  always_ff @(posedge clk) begin
    if (rst) pixels.valid <= 1'b0;
    else if (adv) pixels.valid <= vd[DS];
    if (adv) begin
      pixels.visible  <= vis;
      pixels.screen_x <= vis ? px_ext[SCREEN_BITS-1:0] : '0;
      pixels.screen_y <= vis ? py_ext[SCREEN_BITS-1:0] : '0;
    end
  end

endmodule
